[src/pair_cooccurrence_counter_assert.svh]
// Assertion macros for the pair co-occurrence counter.
`ifndef PAIR_COOCCURRENCE_COUNTER_ASSERT_SVH
`define PAIR_COOCCURRENCE_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCC_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pair counter assertion failed");
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pair counter assertion failed");
`else
`define PCC_ASSERT(label, clk, rst_n, ante, cons)
`define PCC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/pcc_pkg.sv]
package pcc_pkg;

	localparam int DEFAULT_DEPTH = 256;

	localparam int REQ_W  = 2;
	localparam int TOK_W  = 20;
	localparam int DOC_W  = 16;
	localparam int IDX_W  = 8;
	localparam int TF_W   = 32;
	localparam int DF_W   = 16;
	localparam int USED_W = 9;

	localparam logic [TF_W-1:0] TF_MAX = '1;
	localparam logic [DF_W-1:0] DF_MAX = '1;

	typedef enum logic [REQ_W-1:0] {
		REQ_COUNT = 2'd0,
		REQ_READ  = 2'd1,
		REQ_CLEAR = 2'd2
	} req_t;

	typedef struct packed {
		logic [TOK_W-1:0] first;
		logic [TOK_W-1:0] second;
		logic [TF_W-1:0]  tf;
		logic [DF_W-1:0]  df;
		logic [DOC_W-1:0] last_doc;
	} pcc_entry_t;

	typedef struct packed {
		logic       hit;
		pcc_entry_t upd;
	} pcc_match_t;

	typedef struct packed {
		logic [TOK_W-1:0] first;
		logic [TOK_W-1:0] second;
		logic [TF_W-1:0]  tf;
		logic [DF_W-1:0]  df;
		logic             new_pair;
		logic             full;
		logic             valid;
	} pcc_result_t;

endpackage

[src/pcc_table.sv]
module pcc_table #(
	parameter int DEPTH = pcc_pkg::DEFAULT_DEPTH
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  pcc_pkg::pcc_entry_t      wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output pcc_pkg::pcc_entry_t      rd_data
);
	import pcc_pkg::*;

	pcc_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[src/pcc_match.sv]
module pcc_match (
	input  pcc_pkg::pcc_entry_t            entry,
	input  logic [pcc_pkg::TOK_W-1:0]      key_first,
	input  logic [pcc_pkg::TOK_W-1:0]      key_second,
	input  logic [pcc_pkg::DOC_W-1:0]      doc,
	output pcc_pkg::pcc_match_t            result
);
	import pcc_pkg::*;

	always_comb begin
		result.hit = (entry.first == key_first) && (entry.second == key_second);
		result.upd = entry;
		if (entry.tf != TF_MAX) begin
			result.upd.tf = entry.tf + TF_W'(1);
		end
		// The document count moves only when the pair shows up in a document other than its last.
		if (entry.last_doc != doc) begin
			result.upd.last_doc = doc;
			if (entry.df != DF_MAX) begin
				result.upd.df = entry.df + DF_W'(1);
			end
		end
	end

endmodule

[src/pair_cooccurrence_counter.sv]
// Pair co-occurrence counter: a table of TABLE_DEPTH slots counting ordered token pairs.
// A request is taken at a clock edge where start is high and busy is low. Each request
// yields exactly one result beat, shown for one cycle with done high; the receiver
// cannot hold it off, and a new start may be given in the cycle that done is high.
// Count: the occupied slots are scanned one per cycle through a single key comparator.
// A hit updates that slot in place and shows done; a miss inserts at the first free
// slot (or flags table_full) once the last occupied slot has been compared, and an
// empty table takes the pair straight from the request ports with no scan.
// Read by index: an occupied slot is read via ST_READ; others give an empty result.
// Clear, and the unused request code: done one cycle after start.
// The scan length, set by the table's single read port, bounds the rate.
// Slots fill from the bottom and are only freed together, so the fill count alone
// tells which slots are occupied. Reset empties the table at once, with no sweep.
`include "pair_cooccurrence_counter_assert.svh"

module pair_cooccurrence_counter #(
	parameter int TABLE_DEPTH = pcc_pkg::DEFAULT_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [pcc_pkg::REQ_W-1:0]   req_type,
	input  logic [pcc_pkg::TOK_W-1:0]   lead_tok,
	input  logic [pcc_pkg::TOK_W-1:0]   trail_tok,
	input  logic [pcc_pkg::DOC_W-1:0]   doc_id,
	input  logic [pcc_pkg::IDX_W-1:0]   entry_index,
	output logic                        done,
	output logic [pcc_pkg::TOK_W-1:0]   pair_first,
	output logic [pcc_pkg::TOK_W-1:0]   pair_second,
	output logic [pcc_pkg::TF_W-1:0]    pair_tf,
	output logic [pcc_pkg::DF_W-1:0]    pair_df,
	output logic                        new_pair,
	output logic                        table_full,
	output logic                        entry_valid,
	output logic [pcc_pkg::USED_W-1:0]  entries_used
);
	import pcc_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    fill_q;
	logic [AW-1:0]    ptr_q;
	logic [TOK_W-1:0] key_a_q;
	logic [TOK_W-1:0] key_b_q;
	logic [DOC_W-1:0] doc_q;
	logic             done_q;
	pcc_result_t      res_q;
	logic [USED_W-1:0] used_q;

	req_t        req;
	logic        idx_ok;
	logic        scan_last;
	logic        room;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic        wr_en;
	pcc_entry_t  wr_data;
	pcc_entry_t  rd_data;
	pcc_match_t  match;

	assign req       = req_t'(req_type);
	assign busy      = (state_q != ST_IDLE);
	assign idx_ok    = XW'(entry_index) < XW'(fill_q);
	assign scan_last = (CW'(ptr_q) + CW'(1)) >= fill_q;
	assign room      = fill_q < CW'(TABLE_DEPTH);

	pcc_table #(
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	pcc_match u_match (
		.entry     (rd_data),
		.key_first (key_a_q),
		.key_second(key_b_q),
		.doc       (doc_q),
		.result    (match)
	);

	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = match.upd;
		unique case (state_q)
			ST_IDLE: begin
				if (req == REQ_READ) begin
					rd_addr = AW'(entry_index);
				end
				// An empty table takes the new pair straight from the request ports.
				if (start && req == REQ_COUNT && fill_q == '0) begin
					wr_en   = 1'b1;
					wr_addr = '0;
					wr_data = '{first: lead_tok, second: trail_tok,
						tf: TF_W'(1), df: DF_W'(1), last_doc: doc_id};
				end
			end
			ST_SCAN: begin
				rd_addr = ptr_q + AW'(1);
				if (match.hit) begin
					wr_en = 1'b1;
				end else if (scan_last && room) begin
					wr_en   = 1'b1;
					wr_addr = AW'(fill_q);
					wr_data = '{first: key_a_q, second: key_b_q,
						tf: TF_W'(1), df: DF_W'(1), last_doc: doc_q};
				end
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			ptr_q   <= '0;
			key_a_q <= '0;
			key_b_q <= '0;
			doc_q   <= '0;
			done_q  <= 1'b0;
			res_q   <= '0;
			used_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						key_a_q <= lead_tok;
						key_b_q <= trail_tok;
						doc_q   <= doc_id;
						ptr_q   <= '0;
						unique case (req)
							REQ_COUNT: begin
								if (fill_q == '0) begin
									fill_q <= CW'(1);
									res_q  <= '{first: lead_tok, second: trail_tok,
										tf: TF_W'(1), df: DF_W'(1), new_pair: 1'b1,
										full: 1'b0, valid: 1'b1};
									used_q <= USED_W'(CW'(1));
									done_q <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
									done_q  <= 1'b0;
								end
							end
							REQ_READ: begin
								if (idx_ok) begin
									state_q <= ST_READ;
									done_q  <= 1'b0;
								end else begin
									res_q  <= '0;
									used_q <= USED_W'(fill_q);
									done_q <= 1'b1;
								end
							end
							REQ_CLEAR: begin
								fill_q <= '0;
								res_q  <= '0;
								used_q <= '0;
								done_q <= 1'b1;
							end
							default: begin
								res_q  <= '0;
								used_q <= USED_W'(fill_q);
								done_q <= 1'b1;
							end
						endcase
					end else begin
						done_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (match.hit) begin
						res_q <= '{first: match.upd.first, second: match.upd.second,
							tf: match.upd.tf, df: match.upd.df, new_pair: 1'b0,
							full: 1'b0, valid: 1'b1};
						used_q  <= USED_W'(fill_q);
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (scan_last) begin
						if (room) begin
							fill_q <= fill_q + CW'(1);
							res_q  <= '{first: key_a_q, second: key_b_q, tf: TF_W'(1),
								df: DF_W'(1), new_pair: 1'b1, full: 1'b0, valid: 1'b1};
							used_q <= USED_W'(fill_q + CW'(1));
						end else begin
							res_q  <= '{first: key_a_q, second: key_b_q, tf: '0, df: '0,
								new_pair: 1'b0, full: 1'b1, valid: 1'b0};
							used_q <= USED_W'(fill_q);
						end
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						ptr_q  <= ptr_q + AW'(1);
						done_q <= 1'b0;
					end
				end
				ST_READ: begin
					res_q <= '{first: rd_data.first, second: rd_data.second,
						tf: rd_data.tf, df: rd_data.df, new_pair: 1'b0,
						full: 1'b0, valid: 1'b1};
					used_q  <= USED_W'(fill_q);
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign pair_first   = res_q.first;
	assign pair_second  = res_q.second;
	assign pair_tf      = res_q.tf;
	assign pair_df      = res_q.df;
	assign new_pair     = res_q.new_pair;
	assign table_full   = res_q.full;
	assign entry_valid  = res_q.valid;
	assign entries_used = used_q;

	`PCC_ASSERT(a_fill_bound, clk, arst_n, 1'b1, fill_q <= CW'(TABLE_DEPTH))
	`PCC_ASSERT(a_done_idle, clk, arst_n, done, !busy)
	`PCC_ASSERT(a_full_at_depth, clk, arst_n, done && table_full, fill_q == CW'(TABLE_DEPTH))
	`PCC_ASSERT_NEXT(a_clear_empties, clk, arst_n, start && !busy && req == REQ_CLEAR, fill_q == '0)

endmodule
